// File: rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// default sizes of the frame buffer and of the word burst
	localparam int BUFFER_BYTES_DEF = 64;
	localparam int WORD_COUNT_DEF   = 19;

	// field widths
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 7;
	localparam int INDEX_W = 5;
	localparam int WORD_W  = 16;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'h55;
	localparam logic [LEN_W-1:0]  MIN_LEN_RST       = 7'd43;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST       = 7'd50;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN       = 2'd3;

	// frame offsets
	localparam logic [LEN_W-1:0] KIND_OFFSET = 7'd3;
	localparam logic [8:0]       BODY_OFFSET = 9'd4;

	// deframer sequencer
	typedef enum logic [7:0] {
		ST_HEAD1  = 8'b0000_0001,
		ST_HEAD2  = 8'b0000_0010,
		ST_LEN    = 8'b0000_0100,
		ST_BODY   = 8'b0000_1000,
		ST_SUM    = 8'b0001_0000,
		ST_RD_HI  = 8'b0010_0000,
		ST_RD_LO  = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

endpackage

// File: rtl/core/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read; hold data while not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/sensor_frame_deframer.sv
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Header hunt, length check, body buffering and sum-8 checksum check of a
// serial byte stream; emits the frame body as tagged signed 16-bit words.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while parsing; after a checksum byte that
//   matches, the words are drained: each is read as high then low byte over
//   the single buffer read port and then loaded into the output register,
//   the load waiting for a free output slot; the first word is shown once it
//   is loaded, with input held off until the last word is loaded.
// Reset: arst_n clears sequencer, counters, configuration registers and output
//   valid; the buffer is not cleared, every word read was written in the same frame.
// ----------------------------------------------------------------------------
module sensor_frame_deframer #(
	parameter int BUFFER_BYTES = sfd_pkg::BUFFER_BYTES_DEF,
	parameter int WORD_COUNT   = sfd_pkg::WORD_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfd_pkg::BYTE_W-1:0]       cfg_data,
	// byte input
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sfd_pkg::BYTE_W-1:0]       rx_byte,
	// word output
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sfd_pkg::BYTE_W-1:0]       frame_kind,
	output logic [sfd_pkg::INDEX_W-1:0]      word_index,
	output logic signed [sfd_pkg::WORD_W-1:0] word_value,
	output logic                             last_word
);

	localparam int AW      = $clog2(BUFFER_BYTES);
	localparam int MIN_LEN = 2 * WORD_COUNT + 5;
	localparam int LW      = sfd_pkg::LEN_W;
	localparam int BW      = sfd_pkg::BYTE_W;
	localparam int IW      = sfd_pkg::INDEX_W;

	// configuration registers
	logic [BW-1:0] first_header_q;
	logic [BW-1:0] second_header_q;
	logic [LW-1:0] min_len_q;
	logic [LW-1:0] max_len_q;

	// parser state
	sfd_pkg::state_t state_q;
	logic [LW-1:0]   length_q;
	logic [LW-1:0]   taken_q;
	logic [BW-1:0]   sum_q;
	logic [BW-1:0]   kind_q;
	logic [IW-1:0]   word_q;
	logic [BW-1:0]   hi_q;

	// output register
	logic                    out_valid_q;
	logic [BW-1:0]           out_kind_q;
	logic [IW-1:0]           out_index_q;
	logic [sfd_pkg::WORD_W-1:0] out_word_q;
	logic                    out_last_q;

	// buffer port signals
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [BW-1:0] ram_rdata;

	logic               in_fire;
	logic               len_ok;
	logic [LW+AW-1:0]   taken_wide;
	logic [8:0]         hi_off;
	logic [8:0]         lo_off;
	logic [BW:0]        taken_next2;
	logic               word_last;
	logic               slot_free;

	assign in_ready = state_q inside {sfd_pkg::ST_HEAD1, sfd_pkg::ST_HEAD2, sfd_pkg::ST_LEN,
		sfd_pkg::ST_BODY, sfd_pkg::ST_SUM};
	assign in_fire  = in_valid && in_ready;

	// accept a length only within the configured window and what the buffer holds
	assign len_ok = (rx_byte >= {1'b0, min_len_q}) && (rx_byte <= {1'b0, max_len_q}) &&
		(32'(rx_byte) <= BUFFER_BYTES) && (32'(rx_byte) >= MIN_LEN);

	// body write address from the frame offset
	assign taken_wide = (LW + AW)'(taken_q);
	assign ram_waddr  = taken_wide[AW-1:0];
	assign ram_we     = in_fire && (state_q == sfd_pkg::ST_BODY) &&
		(32'(taken_q) < BUFFER_BYTES);

	// drain read address: high byte then low byte of the current word
	assign hi_off    = sfd_pkg::BODY_OFFSET + {3'b000, word_q, 1'b0};
	assign lo_off    = hi_off + 9'd1;
	assign ram_re    = (state_q == sfd_pkg::ST_RD_HI) || (state_q == sfd_pkg::ST_RD_LO);
	assign ram_raddr = (state_q == sfd_pkg::ST_RD_LO) ? lo_off[AW-1:0] : hi_off[AW-1:0];

	assign taken_next2 = {2'b00, taken_q} + 9'd2;
	assign word_last   = (word_q == IW'(WORD_COUNT - 1));
	assign slot_free   = !out_valid_q || out_ready;

	sfd_ram #(
		.WIDTH(BW),
		.DEPTH(BUFFER_BYTES)
	) u_body_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_header_q  <= sfd_pkg::FIRST_HEADER_RST;
			second_header_q <= sfd_pkg::SECOND_HEADER_RST;
			min_len_q       <= sfd_pkg::MIN_LEN_RST;
			max_len_q       <= sfd_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sfd_pkg::CFG_FIRST_HEADER:  first_header_q  <= cfg_data;
				sfd_pkg::CFG_SECOND_HEADER: second_header_q <= cfg_data;
				sfd_pkg::CFG_MIN_LEN:       min_len_q       <= cfg_data[LW-1:0];
				sfd_pkg::CFG_MAX_LEN:       max_len_q       <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// parse sequencer and word drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sfd_pkg::ST_HEAD1;
			length_q <= '0;
			taken_q  <= '0;
			sum_q    <= '0;
			kind_q   <= '0;
			word_q   <= '0;
		end else begin
			case (state_q)
				sfd_pkg::ST_HEAD1: begin
					if (in_fire) begin
						if (rx_byte == first_header_q) begin
							sum_q   <= rx_byte;
							state_q <= sfd_pkg::ST_HEAD2;
						end else begin
							sum_q <= '0;
						end
					end
				end
				sfd_pkg::ST_HEAD2: begin
					if (in_fire) begin
						if (rx_byte == second_header_q) begin
							sum_q   <= sum_q + rx_byte;
							state_q <= sfd_pkg::ST_LEN;
						end else begin
							state_q <= sfd_pkg::ST_HEAD1;
						end
					end
				end
				sfd_pkg::ST_LEN: begin
					if (in_fire) begin
						if (len_ok) begin
							length_q <= rx_byte[LW-1:0];
							sum_q    <= sum_q + rx_byte;
							taken_q  <= sfd_pkg::KIND_OFFSET;
							state_q  <= sfd_pkg::ST_BODY;
						end else begin
							state_q <= sfd_pkg::ST_HEAD1;
						end
					end
				end
				sfd_pkg::ST_BODY: begin
					if (in_fire) begin
						if (taken_q == sfd_pkg::KIND_OFFSET) begin
							kind_q <= rx_byte;
						end
						sum_q   <= sum_q + rx_byte;
						taken_q <= taken_q + 1'b1;
						if (taken_next2 >= {2'b00, length_q}) begin
							state_q <= sfd_pkg::ST_SUM;
						end
					end
				end
				sfd_pkg::ST_SUM: begin
					if (in_fire) begin
						sum_q  <= '0;
						word_q <= '0;
						state_q <= (rx_byte == sum_q) ? sfd_pkg::ST_RD_HI : sfd_pkg::ST_HEAD1;
					end
				end
				sfd_pkg::ST_RD_HI: begin
					state_q <= sfd_pkg::ST_RD_LO;
				end
				sfd_pkg::ST_RD_LO: begin
					state_q <= sfd_pkg::ST_EMIT;
				end
				sfd_pkg::ST_EMIT: begin
					if (slot_free) begin
						if (word_last) begin
							state_q <= sfd_pkg::ST_HEAD1;
						end else begin
							word_q  <= word_q + 1'b1;
							state_q <= sfd_pkg::ST_RD_HI;
						end
					end
				end
				default: begin
					sum_q   <= '0;
					state_q <= sfd_pkg::ST_HEAD1;
				end
			endcase
		end
	end

	// capture the high byte as the low byte read goes out
	always_ff @(posedge clk) begin
		if (state_q == sfd_pkg::ST_RD_LO) begin
			hi_q <= ram_rdata;
		end
	end

	// output valid: set on load, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == sfd_pkg::ST_EMIT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if ((state_q == sfd_pkg::ST_EMIT) && slot_free) begin
			out_kind_q  <= kind_q;
			out_index_q <= word_q;
			out_word_q  <= {hi_q, ram_rdata};
			out_last_q  <= word_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_kind = out_kind_q;
	assign word_index = out_index_q;
	assign word_value = out_word_q;
	assign last_word  = out_last_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sensor_frame_deframer with framed and unframed serial bytes under
// random idling on both handshakes. A local frame tracker predicts every
// word, and each word transaction is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int BUF_BYTES    = sfd_pkg::BUFFER_BYTES_DEF;
	localparam int WORDS        = sfd_pkg::WORD_COUNT_DEF;
	localparam int DRAIN_CYCLES = 3 * WORDS + 16;
	localparam int STALL_LIMIT  = 4000;

	typedef enum logic [4:0] {
		HUNT_FIRST  = 5'b0_0001,
		HUNT_SECOND = 5'b0_0010,
		READ_LEN    = 5'b0_0100,
		READ_BODY   = 5'b0_1000,
		READ_SUM    = 5'b1_0000
	} parse_phase_t;

	typedef struct packed {
		logic [sfd_pkg::BYTE_W-1:0]        kind;
		logic [sfd_pkg::INDEX_W-1:0]       index;
		logic signed [sfd_pkg::WORD_W-1:0] value;
		logic                              last;
	} word_t;

	// block ports
	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              cfg_we    = 1'b0;
	logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index = sfd_pkg::CFG_FIRST_HEADER;
	logic [sfd_pkg::BYTE_W-1:0]        cfg_data  = '0;
	logic                              in_valid  = 1'b0;
	logic                              in_ready;
	logic [sfd_pkg::BYTE_W-1:0]        rx_byte   = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [sfd_pkg::BYTE_W-1:0]        frame_kind;
	logic [sfd_pkg::INDEX_W-1:0]       word_index;
	logic signed [sfd_pkg::WORD_W-1:0] word_value;
	logic                              last_word;

	// frame tracker state and its copy of the registers
	logic [sfd_pkg::BYTE_W-1:0] hdr_first   = sfd_pkg::FIRST_HEADER_RST;
	logic [sfd_pkg::BYTE_W-1:0] hdr_second  = sfd_pkg::SECOND_HEADER_RST;
	logic [sfd_pkg::LEN_W-1:0]  lim_min     = sfd_pkg::MIN_LEN_RST;
	logic [sfd_pkg::LEN_W-1:0]  lim_max     = sfd_pkg::MAX_LEN_RST;
	parse_phase_t               parse_phase = HUNT_FIRST;
	int                         frame_len   = 0;
	int                         taken       = 0;
	logic [sfd_pkg::BYTE_W-1:0] run_sum     = '0;
	logic [sfd_pkg::BYTE_W-1:0] kind_held   = '0;
	logic [sfd_pkg::BYTE_W-1:0] frame_store [BUF_BYTES];

	word_t words_due [$];

	// run bookkeeping
	int  fail_count    = 0;
	int  bytes_sent    = 0;
	int  good_frames   = 0;
	int  words_checked = 0;
	int  cfg_writes    = 0;
	int  quiet_cycles  = 0;
	int  stall_left    = 0;
	bit  no_idle       = 1'b0;

	sensor_frame_deframer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_kind (frame_kind),
		.word_index (word_index),
		.word_value (word_value),
		.last_word  (last_word)
	);

	always #1 clk = ~clk;

	// decide whether a length byte opens a frame
	function automatic bit length_fits(input logic [sfd_pkg::BYTE_W-1:0] len);
		return (len >= lim_min) && (len <= lim_max) && (len <= BUF_BYTES) &&
			(len >= 2 * WORDS + 5);
	endfunction

	// advance the frame tracker by one received byte, queue any words
	task automatic deframe_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
		word_t w;
		case (parse_phase)
			HUNT_FIRST: begin
				run_sum = '0;
				if (b == hdr_first) begin
					run_sum = b;
					parse_phase = HUNT_SECOND;
				end
			end
			HUNT_SECOND: begin
				if (b == hdr_second) begin
					run_sum = run_sum + b;
					parse_phase = READ_LEN;
				end else begin
					parse_phase = HUNT_FIRST;
				end
			end
			READ_LEN: begin
				if (length_fits(b)) begin
					frame_len = b;
					run_sum = run_sum + b;
					taken = 3;
					parse_phase = READ_BODY;
				end else begin
					parse_phase = HUNT_FIRST;
				end
			end
			READ_BODY: begin
				if (taken < BUF_BYTES)
					frame_store[taken] = b;
				if (taken == 3)
					kind_held = b;
				run_sum = run_sum + b;
				taken++;
				if (taken + 1 >= frame_len)
					parse_phase = READ_SUM;
			end
			default: begin
				if (b == run_sum) begin
					for (int k = 0; k < WORDS; k++) begin
						w.kind  = kind_held;
						w.index = sfd_pkg::INDEX_W'(k);
						w.value = {frame_store[4 + 2 * k], frame_store[5 + 2 * k]};
						w.last  = (k == WORDS - 1);
						words_due.push_back(w);
					end
					good_frames++;
				end
				run_sum = '0;
				parse_phase = HUNT_FIRST;
			end
		endcase
	endtask

	// track accepted bytes and register writes, check each word transaction
	always @(posedge clk) begin
		word_t due;
		if (arst_n) begin
			if (in_valid && in_ready)
				deframe_byte(rx_byte);
			if (cfg_we) begin
				case (cfg_index)
					sfd_pkg::CFG_FIRST_HEADER:  hdr_first  = cfg_data;
					sfd_pkg::CFG_SECOND_HEADER: hdr_second = cfg_data;
					sfd_pkg::CFG_MIN_LEN:       lim_min    = cfg_data[sfd_pkg::LEN_W-1:0];
					sfd_pkg::CFG_MAX_LEN:       lim_max    = cfg_data[sfd_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					$error("unexpected word: frame_kind %0h word_index %0d word_value %0d",
						frame_kind, word_index, word_value);
					fail_count++;
				end else begin
					due = words_due.pop_front();
					words_checked++;
					if (frame_kind !== due.kind) begin
						$error("frame_kind: expected %0h, actual %0h", due.kind, frame_kind);
						fail_count++;
					end
					if (word_index !== due.index) begin
						$error("word_index: expected %0d, actual %0d", due.index, word_index);
						fail_count++;
					end
					if (word_value !== due.value) begin
						$error("word_value: expected %0d, actual %0d",
							$signed(due.value), word_value);
						fail_count++;
					end
					if (last_word !== due.last) begin
						$error("last_word: expected %0b, actual %0b", due.last, last_word);
						fail_count++;
					end
				end
			end
		end
	end

	// stall the word side in random bursts
	always @(negedge clk) begin
		if (no_idle) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// send one byte; called and returning at a falling edge, valid left high
	task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// drop valid after the last accepted byte
	task automatic release_input();
		if (in_valid)
			in_valid <= 1'b0;
	endtask

	// hold the sender until every queued word has come out
	task automatic wait_drained();
		release_input();
		while (words_due.size() != 0)
			@(negedge clk);
	endtask

	// feed filler until the tracker hunts for a header again
	task automatic return_to_hunt();
		while (parse_phase != HUNT_FIRST) begin
			case (parse_phase)
				HUNT_SECOND: send_byte(~hdr_second);
				READ_LEN:    send_byte('0);
				default:     send_byte(8'($urandom));
			endcase
		end
	endtask

	// write one register, then drop the write enable again
	task automatic write_reg(input logic [sfd_pkg::CFG_IDX_W-1:0] idx,
			input logic [sfd_pkg::BYTE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cfg_writes++;
	endtask

	// bring the block to rest, then set all four registers
	task automatic apply_config(input logic [sfd_pkg::BYTE_W-1:0] h1,
			input logic [sfd_pkg::BYTE_W-1:0] h2,
			input logic [sfd_pkg::BYTE_W-1:0] mn, input logic [sfd_pkg::BYTE_W-1:0] mx);
		return_to_hunt();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		write_reg(sfd_pkg::CFG_FIRST_HEADER, h1);
		write_reg(sfd_pkg::CFG_SECOND_HEADER, h2);
		write_reg(sfd_pkg::CFG_MIN_LEN, mn);
		write_reg(sfd_pkg::CFG_MAX_LEN, mx);
	endtask

	// build and send a whole frame with the current headers
	task automatic send_frame(input logic [sfd_pkg::BYTE_W-1:0] kind, input int len,
			input bit sum_good, input bit extremes);
		logic [sfd_pkg::BYTE_W-1:0] frame [$];
		logic [sfd_pkg::BYTE_W-1:0] sum;
		logic [sfd_pkg::WORD_W-1:0] pattern;
		frame = {};
		frame.push_back(hdr_first);
		frame.push_back(hdr_second);
		frame.push_back(8'(len));
		frame.push_back(kind);
		for (int off = 4; off <= len - 2; off++) begin
			if (extremes) begin
				case (((off - 4) / 2) % 4)
					0:       pattern = 16'h8000;
					1:       pattern = 16'h7FFF;
					2:       pattern = 16'hFFFF;
					default: pattern = 16'h0000;
				endcase
				frame.push_back((off % 2 == 0) ? pattern[15:8] : pattern[7:0]);
			end else begin
				frame.push_back(8'($urandom));
			end
		end
		sum = '0;
		foreach (frame[i])
			sum = sum + frame[i];
		if (!sum_good)
			sum = sum + 8'($urandom_range(1, 255));
		frame.push_back(sum);
		foreach (frame[i])
			send_byte(frame[i]);
	endtask

	// send a header stub that breaks off or goes astray
	task automatic send_broken();
		logic [sfd_pkg::BYTE_W-1:0] v;
		case ($urandom_range(0, 2))
			0: begin
				v = 8'($urandom);
				if (v == hdr_second)
					v = ~v;
				send_byte(hdr_first);
				send_byte(v);
			end
			1: begin
				send_byte(hdr_first);
				send_byte(hdr_second);
				send_byte(8'($urandom));
			end
			default: begin
				send_byte(hdr_first);
				send_byte(hdr_second);
				send_byte(8'($urandom_range(43, 64)));
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end
		endcase
	endtask

	// default registers, words at the signed extremes
	task automatic test_defaults();
		send_frame(8'h00, 43, 1'b1, 1'b1);
	endtask

	// a wrong second header and a rejected length byte are not rechecked
	task automatic test_header_hunt();
		send_byte(hdr_first);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(8'd51);
		send_frame(8'h5A, 44, 1'b1, 1'b0);
	endtask

	// a wrong checksum gives nothing, the next frame gets through
	task automatic test_checksum();
		send_frame(8'h81, 43, 1'b0, 1'b0);
		send_frame(8'hFF, 50, 1'b1, 1'b0);
	endtask

	// register extremes, crossed limits, buffer ceiling and length floor, wide writes
	task automatic test_registers();
		apply_config(8'h00, 8'hFF, 8'd43, 8'd43);
		send_frame(8'h3C, 43, 1'b1, 1'b0);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(8'd44);
		apply_config(8'hFF, 8'h00, 8'd64, 8'd64);
		send_frame(8'hC3, 64, 1'b1, 1'b1);
		apply_config(sfd_pkg::FIRST_HEADER_RST, sfd_pkg::SECOND_HEADER_RST, 8'd64, 8'd43);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(8'd50);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(8'd43);
		apply_config(sfd_pkg::FIRST_HEADER_RST, sfd_pkg::SECOND_HEADER_RST, 8'd32, 8'h7F);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(8'd65);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(8'd42);
		send_frame(8'h11, 64, 1'b1, 1'b0);
		apply_config(sfd_pkg::FIRST_HEADER_RST, sfd_pkg::SECOND_HEADER_RST, 8'hAB, 8'hB2);
		send_frame(8'h22, 43, 1'b1, 1'b0);
	endtask

	// random registers, mostly well-formed frames, some stubs and noise
	task automatic test_random_traffic();
		int stop_at;
		int lo;
		int hi;
		int len;
		logic [sfd_pkg::BYTE_W-1:0] mn;
		logic [sfd_pkg::BYTE_W-1:0] mx;
		for (int p = 0; p < 2; p++) begin
			mn = 8'($urandom_range(43, 64));
			if ($urandom_range(0, 7) == 0)
				mx = 8'($urandom_range(43, mn));
			else
				mx = 8'($urandom_range(mn, 64));
			apply_config(8'($urandom), 8'($urandom), mn, mx);
			stop_at = bytes_sent + 16;
			while (bytes_sent < stop_at) begin
				case ($urandom_range(0, 9))
					7: send_broken();
					8, 9: repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
					default: begin
						lo = lim_min;
						hi = lim_max;
						if (lo > hi) begin
							lo = 43;
							hi = 64;
						end
						if ($urandom_range(0, 4) == 0)
							len = hi;
						else
							len = lo + $urandom_range(0, (hi - lo < 3) ? hi - lo : 3);
						send_frame(8'($urandom), len, $urandom_range(0, 6) != 0, 1'b0);
					end
				endcase
			end
		end
	endtask

	// frames back to back with both sides always ready
	task automatic test_no_idle();
		apply_config(sfd_pkg::FIRST_HEADER_RST, sfd_pkg::SECOND_HEADER_RST,
			sfd_pkg::MIN_LEN_RST, sfd_pkg::MAX_LEN_RST);
		no_idle = 1'b1;
		send_frame(8'h96, 43, 1'b1, 1'b0);
		send_frame(8'h69, 50, 1'b1, 1'b0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_defaults();
		test_header_hunt();
		test_checksum();
		test_registers();
		test_random_traffic();
		test_no_idle();

		// let the last words drain and the block settle
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (words_due.size() != 0) begin
			$error("words still expected at end: %0d", words_due.size());
			fail_count++;
		end

		$display("Sent %0d bytes over %0d register writes; %0d frames passed the checksum.",
			bytes_sent, cfg_writes, good_frames);
		$display("Checked %0d words against the frame tracker.", words_checked);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
